[src/rrrs_pkg.sv]
// Shared types and constants for the replica round-robin rank/slot unit.
`default_nettype none
package rrrs_pkg;

  localparam int TURN_W     = 32;
  localparam int DIV_DW     = 32;
  localparam int DIV_VW     = 11;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_CW     = $clog2(DIV_DW / DIV_RADIX + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_PER_RANK = 2'd1;

  localparam logic [8:0]  LOGICAL_COUNT_RST    = 9'd256;
  localparam logic [10:0] EXPERTS_PER_RANK_RST = 11'd1;

  localparam logic [1:0] REQ_MAP_LOAD   = 2'd0;
  localparam logic [1:0] REQ_COUNT_LOAD = 2'd1;
  localparam logic [1:0] REQ_REMAP      = 2'd2;
  localparam logic [1:0] REQ_UNUSED     = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_ID  = 2'd1;
  localparam logic [1:0] STAT_NO_COPY = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] logical_id;
    logic [2:0]         copy_index;
    logic [9:0]         physical_id;
    logic [3:0]         copy_total;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] dest_rank;
    logic [9:0] slot_in_rank;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
    logic [DIV_VW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_READ,
    S_MOD,
    S_MAP,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[src/rrrs_div.sv]
// Shared restoring divider, DIV_RADIX quotient bits per cycle.
`default_nettype none
module rrrs_div import rrrs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] dvd_r, dvd_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dsr_r, dsr_nxt;
  logic [DIV_DW-1:0] dvd_step;
  logic [DIV_VW-1:0] rem_step;

  always_comb begin
    logic [DIV_VW:0]   t;
    logic [DIV_VW-1:0] r;
    logic [DIV_DW-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t = {r, d[DIV_DW-1]};
      d = {d[DIV_DW-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t    = t - {1'b0, dsr_r};
        d[0] = 1'b1;
      end
      r = t[DIV_VW-1:0];
    end
    dvd_step = d;
    rem_step = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = dvd_step;
      rem_nxt = rem_step;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

[src/rrrs_tables.sv]
// Copy map, copy count and turn counter memories with reset clearing sweep.
`default_nettype none
module rrrs_tables import rrrs_pkg::*; #(
  parameter int MAX_LOGICAL  = 256,
  parameter int MAX_COPIES   = 8,
  parameter int PHYS_ID_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  output logic                                   clearing,
  input  wire logic [$clog2(MAX_LOGICAL)-1:0]    row,
  input  wire logic                              rd_en,
  input  wire logic                              cnt_we,
  input  wire logic [$clog2(MAX_COPIES+1)-1:0]   cnt_wdata,
  input  wire logic                              turn_we,
  input  wire logic [TURN_W-1:0]                 turn_wdata,
  output logic [$clog2(MAX_COPIES+1)-1:0]        cnt_rdata,
  output logic [TURN_W-1:0]                      turn_rdata,
  input  wire logic [$clog2(MAX_LOGICAL*MAX_COPIES)-1:0] map_addr,
  input  wire logic                              map_we,
  input  wire logic [PHYS_ID_BITS-1:0]           map_wdata,
  input  wire logic                              map_rd_en,
  output logic [PHYS_ID_BITS-1:0]                map_rdata
);

  localparam int LOG_W     = $clog2(MAX_LOGICAL);
  localparam int CNT_W     = $clog2(MAX_COPIES + 1);
  localparam int MAP_DEPTH = MAX_LOGICAL * MAX_COPIES;

  logic [CNT_W-1:0]        cnt_mem  [MAX_LOGICAL];
  logic [TURN_W-1:0]       turn_mem [MAX_LOGICAL];
  logic [PHYS_ID_BITS-1:0] map_mem  [MAP_DEPTH];

  logic                    clearing_r, clearing_nxt;
  logic [LOG_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic [LOG_W-1:0]        waddr;
  logic                    cnt_wr, turn_wr;
  logic [CNT_W-1:0]        cnt_wd;
  logic [TURN_W-1:0]       turn_wd;
  logic [CNT_W-1:0]        cnt_rdata_r;
  logic [TURN_W-1:0]       turn_rdata_r;
  logic [PHYS_ID_BITS-1:0] map_rdata_r;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == LOG_W'(MAX_LOGICAL - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    waddr   = clearing_r ? clr_idx_r : row;
    cnt_wr  = clearing_r || cnt_we;
    turn_wr = clearing_r || turn_we;
    cnt_wd  = clearing_r ? '0 : cnt_wdata;
    turn_wd = clearing_r ? '0 : turn_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[waddr] <= cnt_wd;
    end
    if (rd_en) begin
      cnt_rdata_r <= cnt_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (turn_wr) begin
      turn_mem[waddr] <= turn_wd;
    end
    if (rd_en) begin
      turn_rdata_r <= turn_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wdata;
    end
    if (map_rd_en) begin
      map_rdata_r <= map_mem[map_addr];
    end
  end

  assign clearing   = clearing_r;
  assign cnt_rdata  = cnt_rdata_r;
  assign turn_rdata = turn_rdata_r;
  assign map_rdata  = map_rdata_r;

endmodule
`default_nettype wire

[src/replica_round_robin_rank_slot_unit.sv]
// Top level of the replica round-robin rank/slot unit.
// Loads of the copy map or copy counts write their table from S_LOOK and give no result. A
// remap of a bad id or an id with no copy goes to S_DONE without using the divider. A
// single-copy remap reads its map entry directly and uses the divider once, for rank and
// slot; a multi-copy remap first uses the one shared divider, retiring 4 quotient bits a
// cycle, for the turn counter modulo and then for rank and slot.
// in_stall is high while an item is in flight. After reset a clearing pass over all
// MAX_LOGICAL rows zeroes copy counts and turn counters with in_stall held high;
// configuration writes are taken throughout.
`default_nettype none
module replica_round_robin_rank_slot_unit import rrrs_pkg::*; #(
  parameter int MAX_LOGICAL  = 256,
  parameter int MAX_COPIES   = 8,
  parameter int PHYS_ID_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_beat,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_beat,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LOG_W    = $clog2(MAX_LOGICAL);
  localparam int CNT_W    = $clog2(MAX_COPIES + 1);
  localparam int SLOT_W   = (MAX_COPIES > 1) ? $clog2(MAX_COPIES) : 1;
  localparam int MAP_AW   = $clog2(MAX_LOGICAL * MAX_COPIES);
  localparam int PHYS_PAD = ((PHYS_ID_BITS + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
  localparam logic [DIV_CW-1:0] MOD_STEPS  = DIV_CW'(DIV_DW / DIV_RADIX);
  localparam logic [DIV_CW-1:0] PHYS_STEPS = DIV_CW'(PHYS_PAD / DIV_RADIX);

  state_t      state_r, state_nxt;
  in_beat_t    req_r, req_nxt;
  out_beat_t   res_r, res_nxt;
  out_beat_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [8:0]  logical_count_r, logical_count_nxt;
  logic [10:0] epr_r, epr_nxt;

  logic                    clearing;
  logic                    in_take;
  logic                    id_nonneg, row_ok, id_ok, col_ok;
  logic [14:0]             id_low;
  logic [LOG_W-1:0]        row;
  logic [MAP_AW-1:0]       row_base;
  logic [CNT_W-1:0]        count_sat;
  logic [DIV_VW-1:0]       epr_div;
  logic [SLOT_W-1:0]       slot;
  logic                    rd_en, cnt_we, turn_we, map_we, map_rd_en;
  logic [MAP_AW-1:0]       map_addr;
  logic [CNT_W-1:0]        cnt_rdata;
  logic [TURN_W-1:0]       turn_rdata;
  logic [PHYS_ID_BITS-1:0] map_rdata;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  rrrs_tables #(
    .MAX_LOGICAL  (MAX_LOGICAL),
    .MAX_COPIES   (MAX_COPIES),
    .PHYS_ID_BITS (PHYS_ID_BITS)
  ) u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .row        (row),
    .rd_en      (rd_en),
    .cnt_we     (cnt_we),
    .cnt_wdata  (count_sat),
    .turn_we    (turn_we),
    .turn_wdata (turn_rdata + 1'b1),
    .cnt_rdata  (cnt_rdata),
    .turn_rdata (turn_rdata),
    .map_addr   (map_addr),
    .map_we     (map_we),
    .map_wdata  (PHYS_ID_BITS'(req_r.physical_id)),
    .map_rd_en  (map_rd_en),
    .map_rdata  (map_rdata)
  );

  rrrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = clearing || (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    id_nonneg = !req_r.logical_id[15];
    id_low    = req_r.logical_id[14:0];
    row_ok    = id_nonneg && (32'(id_low) < MAX_LOGICAL);
    id_ok     = row_ok && (id_low < 15'(logical_count_r));
    col_ok    = 32'(req_r.copy_index) < MAX_COPIES;
    row       = LOG_W'(id_low);
    row_base  = MAP_AW'(row) * MAP_AW'(MAX_COPIES);
    count_sat = (32'(req_r.copy_total) > MAX_COPIES) ? CNT_W'(MAX_COPIES)
                                                     : CNT_W'(req_r.copy_total);
    epr_div   = (epr_r == '0) ? DIV_VW'(1) : epr_r;
    slot      = SLOT_W'(div_rsp.remainder);
  end

  always_comb begin
    logical_count_nxt = logical_count_r;
    epr_nxt           = epr_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOGICAL_COUNT:    logical_count_nxt = 9'(cfg_data);
        CFG_EXPERTS_PER_RANK: epr_nxt = cfg_data;
        default:              ;
      endcase
    end
  end

  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    res_nxt          = res_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;
    rd_en            = 1'b0;
    cnt_we           = 1'b0;
    turn_we          = 1'b0;
    map_we           = 1'b0;
    map_rd_en        = 1'b0;
    map_addr         = row_base + MAP_AW'(slot);
    div_req.start    = 1'b0;
    div_req.dividend = turn_rdata;
    div_req.divisor  = DIV_VW'(cnt_rdata);
    div_req.steps    = MOD_STEPS;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          req_nxt   = in_beat;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        res_nxt = '{dest_rank: '0, slot_in_rank: '0, status: STAT_OK};
        case (req_r.req_type)
          REQ_MAP_LOAD: begin
            map_addr  = row_base + MAP_AW'(req_r.copy_index);
            map_we    = row_ok && col_ok;
            state_nxt = S_IDLE;
          end
          REQ_COUNT_LOAD: begin
            cnt_we    = row_ok;
            state_nxt = S_IDLE;
          end
          REQ_REMAP: begin
            if (id_ok) begin
              rd_en     = 1'b1;
              state_nxt = S_READ;
            end else begin
              res_nxt.status = STAT_BAD_ID;
              state_nxt      = S_DONE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_READ: begin
        if (cnt_rdata == '0) begin
          res_nxt.status = STAT_NO_COPY;
          state_nxt      = S_DONE;
        end else if (cnt_rdata == CNT_W'(1)) begin
          map_addr  = row_base;
          map_rd_en = 1'b1;
          state_nxt = S_MAP;
        end else begin
          turn_we       = 1'b1;
          div_req.start = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        if (div_rsp.done) begin
          map_rd_en = 1'b1;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(map_rdata) << (DIV_DW - PHYS_PAD);
        div_req.divisor  = epr_div;
        div_req.steps    = PHYS_STEPS;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt.dest_rank    = 10'(div_rsp.quotient);
          res_nxt.slot_in_rank = 10'(div_rsp.remainder);
          state_nxt            = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      logical_count_r <= LOGICAL_COUNT_RST;
      epr_r           <= EXPERTS_PER_RANK_RST;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      logical_count_r <= logical_count_nxt;
      epr_r           <= epr_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

[src/rrrs_chk.sv]
// Port-level checker for the replica round-robin rank/slot unit, with its bind.
`default_nettype none
module rrrs_chk import rrrs_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_beat
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while an item is in flight");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("block not ready when a result appears");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.status == STAT_OK || out_beat.status == STAT_BAD_ID ||
                   out_beat.status == STAT_NO_COPY))
    else $error("undefined status code");

endmodule

bind replica_round_robin_rank_slot_unit rrrs_chk u_rrrs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
`default_nettype wire

[bench/tb_replica_round_robin_rank_slot_unit.sv]
// Testbench for the replica round-robin rank/slot unit: directed table, random phases, self-check.
`default_nettype none
module tb_replica_round_robin_rank_slot_unit;
  import rrrs_pkg::*;

  localparam int NUM_IDS    = 256;
  localparam int NUM_COPIES = 8;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 235;
  localparam int DRAIN      = 40;
  localparam int HOLD       = 300;
  localparam int LIMIT      = 500000;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  replica_round_robin_rank_slot_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block state
  logic [9:0]  map_mirror [NUM_IDS*NUM_COPIES];
  bit   [3:0]  count_mirror [NUM_IDS];
  bit   [31:0] turn_mirror [NUM_IDS];
  int          lc_mirror = 256;
  int          epr_mirror = 1;

  // what the stimulus side has already loaded, so no unwritten entry is ever read
  bit          gen_written [NUM_IDS*NUM_COPIES];
  bit   [3:0]  gen_count [NUM_IDS];

  out_beat_t   pending_routes [$];
  plan_row_t   plan [$];

  int  errors = 0;
  int  cycles = 0;
  int  beats_taken = 0;
  int  routes_ok = 0;
  int  routes_bad_id = 0;
  int  routes_no_copy = 0;
  int  settings_used = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task automatic route_request(input in_beat_t b, output bit got, output out_beat_t r);
    int sid;
    int unsigned nv, slot, phys, dv;
    sid = int'(b.logical_id);
    got = 1'b0;
    r = '0;
    case (b.req_type)
      REQ_MAP_LOAD: begin
        if (sid >= 0 && sid < NUM_IDS && b.copy_index < NUM_COPIES)
          map_mirror[sid*NUM_COPIES + b.copy_index] = b.physical_id;
      end
      REQ_COUNT_LOAD: begin
        if (sid >= 0 && sid < NUM_IDS)
          count_mirror[sid] = (b.copy_total > NUM_COPIES) ? 4'(NUM_COPIES) : b.copy_total;
      end
      REQ_REMAP: begin
        got = 1'b1;
        if (sid < 0 || sid >= lc_mirror || sid >= NUM_IDS) begin
          r.status = STAT_BAD_ID;
        end else if (count_mirror[sid] == 0) begin
          r.status = STAT_NO_COPY;
        end else begin
          nv = 32'(count_mirror[sid]);
          slot = 0;
          if (nv > 1) begin
            slot = turn_mirror[sid] % nv;
            turn_mirror[sid] = turn_mirror[sid] + 1;
          end
          phys = 32'(map_mirror[sid*NUM_COPIES + slot]);
          dv = (epr_mirror == 0) ? 1 : epr_mirror;
          r.dest_rank    = 10'(phys / dv);
          r.slot_in_rank = 10'(phys % dv);
          r.status       = STAT_OK;
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_beat_t rand_fields();
    in_beat_t b;
    b.req_type    = 2'($urandom);
    b.logical_id  = 16'($urandom);
    b.copy_index  = 3'($urandom);
    b.physical_id = 10'($urandom);
    b.copy_total  = 4'($urandom);
    return b;
  endfunction

  function automatic plan_row_t row(input logic [1:0] rt, input int id, input int ci,
                                    input int pid, input int tot, input bit typed,
                                    input logic [1:0] st, input int rk, input int sl);
    plan_row_t p;
    p.beat.req_type    = rt;
    p.beat.logical_id  = id[15:0];
    p.beat.copy_index  = ci[2:0];
    p.beat.physical_id = pid[9:0];
    p.beat.copy_total  = tot[3:0];
    p.typed            = typed;
    p.want.dest_rank    = rk[9:0];
    p.want.slot_in_rank = sl[9:0];
    p.want.status       = st;
    return p;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send(input in_beat_t b, input bit typed, input out_beat_t want);
    int sid;
    bit got;
    out_beat_t r;
    sid = int'(b.logical_id);
    if (sid >= 0 && sid < NUM_IDS) begin
      if (b.req_type == REQ_MAP_LOAD)
        gen_written[sid*NUM_COPIES + b.copy_index] = 1'b1;
      else if (b.req_type == REQ_COUNT_LOAD)
        gen_count[sid] = (b.copy_total > NUM_COPIES) ? 4'(NUM_COPIES) : b.copy_total;
    end
    while (!calm && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (in_stall);
    beats_taken++;
    route_request(b, got, r);
    if (got) begin
      pending_routes.push_back(typed ? want : r);
      case (r.status)
        STAT_OK:      routes_ok++;
        STAT_BAD_ID:  routes_bad_id++;
        default:      routes_no_copy++;
      endcase
    end
    @(negedge clk);
  endtask

  // a remap first gets any copy entries it could read loaded
  task automatic offer(input in_beat_t b);
    int sid;
    in_beat_t fill;
    sid = int'(b.logical_id);
    if (b.req_type == REQ_REMAP && sid >= 0 && sid < NUM_IDS)
      for (int c = 0; c < gen_count[sid]; c++)
        if (!gen_written[sid*NUM_COPIES + c]) begin
          fill = rand_fields();
          fill.req_type   = REQ_MAP_LOAD;
          fill.logical_id = 16'(sid);
          fill.copy_index = 3'(c);
          send(fill, 1'b0, '0);
        end
    send(b, 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LOGICAL_COUNT)
      lc_mirror = data & 'h1FF;
    else if (idx == CFG_EXPERTS_PER_RANK)
      epr_mirror = data & 'h7FF;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int pick_id(input int lc);
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(15);
    if (r < 85) return $urandom_range(NUM_IDS - 1);
    if (r < 92) return (lc == 0) ? 0 : lc - $urandom_range(1);
    return $signed(16'($urandom));
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_routes.size() == 0) begin
        report("unexpected result, status", out_beat.status, -1);
      end else begin
        want = pending_routes.pop_front();
        if (out_beat.dest_rank !== want.dest_rank)
          report("dest_rank", out_beat.dest_rank, want.dest_rank);
        if (out_beat.slot_in_rank !== want.slot_in_rank)
          report("slot_in_rank", out_beat.slot_in_rank, want.slot_in_rank);
        if (out_beat.status !== want.status)
          report("status", out_beat.status, want.status);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, pending_routes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    int k, lcv, eprv, id;

    // no copies anywhere yet
    plan.push_back(row(REQ_REMAP, 0, 0, 0, 0, 1, STAT_NO_COPY, 0, 0));
    plan.push_back(row(REQ_REMAP, -32768, 0, 0, 0, 1, STAT_BAD_ID, 0, 0));
    plan.push_back(row(REQ_REMAP, 32767, 7, 1023, 15, 1, STAT_BAD_ID, 0, 0));
    plan.push_back(row(REQ_REMAP, 256, 0, 0, 0, 1, STAT_BAD_ID, 0, 0));
    plan.push_back(row(REQ_REMAP, -1, 0, 0, 0, 1, STAT_BAD_ID, 0, 0));
    plan.push_back(row(REQ_UNUSED, 0, 7, 1023, 15, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_MAP_LOAD, 0, 0, 1023, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_COUNT_LOAD, 0, 0, 0, 1, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_REMAP, 0, 0, 0, 0, 1, STAT_OK, 1023, 0));
    plan.push_back(row(REQ_MAP_LOAD, 255, 0, 0, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_MAP_LOAD, 255, 1, 512, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_MAP_LOAD, 255, 2, 341, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_COUNT_LOAD, 255, 0, 0, 3, 0, STAT_OK, 0, 0));
    // loads outside the tables must not alias onto rows 0 or 255
    plan.push_back(row(REQ_MAP_LOAD, -1, 0, 77, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_MAP_LOAD, 256, 0, 77, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_COUNT_LOAD, 256, 0, 0, 8, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_COUNT_LOAD, -32768, 0, 0, 8, 0, STAT_OK, 0, 0));
    for (int i = 0; i < 4; i++)
      plan.push_back(row(REQ_REMAP, 255, 0, 0, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_REMAP, 0, 0, 0, 0, 1, STAT_OK, 1023, 0));
    plan.push_back(row(REQ_COUNT_LOAD, 1, 0, 0, 15, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_COUNT_LOAD, 0, 0, 0, 0, 0, STAT_OK, 0, 0));
    plan.push_back(row(REQ_REMAP, 0, 0, 0, 0, 1, STAT_NO_COPY, 0, 0));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      send(plan[i].beat, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid = 1'b0;
      while (pending_routes.size() != 0) @(negedge clk);
      repeat (DRAIN) @(negedge clk);
      case (ph)
        0: begin lcv = 256;  eprv = 0;    end
        1: begin lcv = 1;    eprv = 1024; end
        2: begin lcv = 16;   eprv = 3;    end
        3: begin lcv = 'h7FF; eprv = 2047; end
        4: begin lcv = 256;  eprv = 7;    end
        5: begin lcv = 0;    eprv = 5;    end
        6: begin lcv = 200;  eprv = 1;    end
        default: begin lcv = $urandom_range(1, 256); eprv = $urandom_range(1, 1024); end
      endcase
      cfg_write(CFG_LOGICAL_COUNT, lcv);
      cfg_write(CFG_EXPERTS_PER_RANK, eprv);
      settings_used++;
      calm = (ph == 4);

      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 2 && i == 40)
          hold_req = 1'b1;
        if (ph == 5 && i == 120) begin
          in_valid = 1'b0;
          while (pending_routes.size() != 0) @(negedge clk);
        end
        b  = rand_fields();
        id = pick_id(lc_mirror);
        k  = $urandom_range(99);
        if (k < 50) begin
          b.req_type = REQ_REMAP;
          b.logical_id = id[15:0];
        end else if (k < 72) begin
          b.req_type = REQ_MAP_LOAD;
          b.logical_id = id[15:0];
        end else if (k < 90) begin
          b.req_type = REQ_COUNT_LOAD;
          b.logical_id = id[15:0];
          if ($urandom_range(99) < 80)
            b.copy_total = 4'($urandom_range(NUM_COPIES));
        end else if (k < 94) begin
          b.req_type = REQ_UNUSED;
        end
        offer(b);
      end
    end
    calm = 1'b0;

    in_valid = 1'b0;
    while (pending_routes.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Covered %0d beats over %0d register settings plus reset values", beats_taken,
             settings_used);
    $display("Remap results: %0d ok, %0d bad id, %0d no copy; %0d mismatches", routes_ok,
             routes_bad_id, routes_no_copy, errors);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

[replica_round_robin_rank_slot_unit.f]
src/rrrs_pkg.sv
src/rrrs_div.sv
src/rrrs_tables.sv
src/replica_round_robin_rank_slot_unit.sv
src/rrrs_chk.sv
bench/tb_replica_round_robin_rank_slot_unit.sv
